// File: rtl/apf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apf_pkg: shared types and constants for the articulation point finder
// Payload structs, command codes and controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package apf_pkg;

   localparam int VERTEX_W     = 6;
   localparam int CFG_W        = 7;
   localparam int MAX_VERT_DEF = 64;
   localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

   // request opcodes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   // datapath commands
   localparam int CMD_W = 4;
   localparam logic [CMD_W-1:0] CMD_NOP      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ACCEPT   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_EDGE_RDA = 4'd2;
   localparam logic [CMD_W-1:0] CMD_EDGE_WRA = 4'd3;
   localparam logic [CMD_W-1:0] CMD_EDGE_RDB = 4'd4;
   localparam logic [CMD_W-1:0] CMD_EDGE_WRB = 4'd5;
   localparam logic [CMD_W-1:0] CMD_RUN_INIT = 4'd6;
   localparam logic [CMD_W-1:0] CMD_ROOT_SKIP = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PUSH_ROOT = 4'd8;
   localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 4'd9;
   localparam logic [CMD_W-1:0] CMD_SCAN     = 4'd10;
   localparam logic [CMD_W-1:0] CMD_POP      = 4'd11;
   localparam logic [CMD_W-1:0] CMD_BACK     = 4'd12;
   localparam logic [CMD_W-1:0] CMD_WALK_END = 4'd13;
   localparam logic [CMD_W-1:0] CMD_EMIT     = 4'd14;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd15;

   typedef struct packed {
      logic                opcode;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] ap_vertex;
      logic [VERTEX_W-1:0] ap_count;
      logic                none_found;
      logic                bad_edge_seen;
      logic                is_last;
   } rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic req_add;
      logic req_bad;
      logic root_done;
      logic root_visited;
      logic scan_done;
      logic scan_back;
      logic scan_push;
      logic depth_one;
      logic emit_done;
   } status_type;

endpackage

// File: rtl/apf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apf_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module apf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/apf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apf_ctrl: sequencer for edge loads, the depth-first walk and emission
// Picks one datapath command per cycle from the datapath status.
// ---------------------------------------------------------------------------
module apf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  apf_pkg::status_type st,
   output apf_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EA_RD = 4'd1;
   localparam logic [3:0] S_EA_WR = 4'd2;
   localparam logic [3:0] S_EB_RD = 4'd3;
   localparam logic [3:0] S_EB_WR = 4'd4;
   localparam logic [3:0] S_INIT  = 4'd5;
   localparam logic [3:0] S_ROOT  = 4'd6;
   localparam logic [3:0] S_LOAD  = 4'd7;
   localparam logic [3:0] S_SCAN  = 4'd8;
   localparam logic [3:0] S_POP   = 4'd9;
   localparam logic [3:0] S_BACK  = 4'd10;
   localparam logic [3:0] S_WEND  = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;
   localparam logic [3:0] S_CLEAR = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = apf_pkg::CMD_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = apf_pkg::CMD_ACCEPT;
               if (!st.req_add) begin
                  state_in = S_INIT;
               end else if (!st.req_bad) begin
                  state_in = S_EA_RD;
               end
            end
         end
         S_EA_RD: begin
            cmd.op   = apf_pkg::CMD_EDGE_RDA;
            state_in = S_EA_WR;
         end
         S_EA_WR: begin
            cmd.op   = apf_pkg::CMD_EDGE_WRA;
            state_in = S_EB_RD;
         end
         S_EB_RD: begin
            cmd.op   = apf_pkg::CMD_EDGE_RDB;
            state_in = S_EB_WR;
         end
         S_EB_WR: begin
            cmd.op   = apf_pkg::CMD_EDGE_WRB;
            state_in = S_IDLE;
         end
         S_INIT: begin
            cmd.op   = apf_pkg::CMD_RUN_INIT;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (st.root_done) begin
               state_in = S_EMIT;
            end else if (st.root_visited) begin
               cmd.op = apf_pkg::CMD_ROOT_SKIP;
            end else begin
               cmd.op   = apf_pkg::CMD_PUSH_ROOT;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.op   = apf_pkg::CMD_LOAD_ROW;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = apf_pkg::CMD_SCAN;
            priority if (st.scan_done) begin
               state_in = st.depth_one ? S_WEND : S_POP;
            end else if (st.scan_back) begin
               state_in = S_BACK;
            end else if (st.scan_push) begin
               state_in = S_LOAD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_POP: begin
            cmd.op   = apf_pkg::CMD_POP;
            state_in = S_LOAD;
         end
         S_BACK: begin
            cmd.op   = apf_pkg::CMD_BACK;
            state_in = S_SCAN;
         end
         S_WEND: begin
            cmd.op   = apf_pkg::CMD_WALK_END;
            state_in = S_ROOT;
         end
         S_EMIT: begin
            cmd.op = apf_pkg::CMD_EMIT;
            if (st.emit_done) begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.op   = apf_pkg::CMD_CLEAR;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/apf_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apf_dp: datapath of the articulation point finder
// Adjacency, discovery time and walk stack memories, the stack top registers,
// point mask, result register and configuration register.
// ---------------------------------------------------------------------------
module apf_dp #(
   parameter int MAX_VERTICES = apf_pkg::MAX_VERT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  apf_pkg::cmd_type                cmd,
   output apf_pkg::status_type             st,
   input  apf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output apf_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [apf_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int SW = 2 * VW + 3 * CW;
   localparam int FW = apf_pkg::CFG_W;

   // configuration and item
   logic [FW-1:0]          vc_ff, vc_in;
   apf_pkg::req_type       item_ff, item_in;
   logic                   bad_ff, bad_in;

   // walk state
   logic [CW-1:0]          time_ff, time_in;
   logic [CW-1:0]          root_ff, root_in;
   logic [CW-1:0]          depth_ff, depth_in;
   logic [VW-1:0]          top_v_ff, top_v_in;
   logic [CW-1:0]          top_s_ff, top_s_in;
   logic [CW-1:0]          top_disc_ff, top_disc_in;
   logic [CW-1:0]          top_low_ff, top_low_in;
   logic [VW-1:0]          top_par_ff, top_par_in;
   logic [MAX_VERTICES-1:0] top_row_ff, top_row_in;
   logic [CW-1:0]          child_low_ff, child_low_in;
   logic [CW-1:0]          rc_ff, rc_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic                   row_vld_q_ff;

   // results
   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [VW-1:0]          ev_ff, ev_in;
   logic [CW-1:0]          sent_ff, sent_in;
   apf_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                   adj_we;
   logic [VW-1:0]          adj_waddr, adj_raddr;
   logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, adj_row;
   logic                   disc_we;
   logic [VW-1:0]          disc_waddr, disc_raddr;
   logic [CW-1:0]          disc_wdata, disc_rdata;
   logic                   stk_we;
   logic [VW-1:0]          stk_waddr, stk_raddr;
   logic [SW-1:0]          stk_wdata, stk_rdata;

   // helpers
   logic [FW-1:0]          n_full;
   logic [CW-1:0]          n;
   logic [VW-1:0]          a_idx, b_idx, root_idx, s_idx;
   logic [CW-1:0]          t1, dm1, dm2;
   logic                   hit, out_free, ev_hit, last_item;
   logic [VW-1:0]          e_v, e_par;
   logic [CW-1:0]          e_s, e_disc, e_low;

   apf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_waddr), .wr_data(adj_wdata),
      .rd_addr(adj_raddr), .rd_data(adj_rdata)
   );

   apf_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_disc (
      .clock(clock), .wr_en(disc_we), .wr_addr(disc_waddr), .wr_data(disc_wdata),
      .rd_addr(disc_raddr), .rd_data(disc_rdata)
   );

   apf_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stk (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   // effective vertex count and indices
   assign n_full   = (vc_ff > FW'(MAX_VERTICES)) ? FW'(MAX_VERTICES) : vc_ff;
   assign n        = n_full[CW-1:0];
   assign a_idx    = item_ff.from_vertex[VW-1:0];
   assign b_idx    = item_ff.to_vertex[VW-1:0];
   assign root_idx = root_ff[VW-1:0];
   assign s_idx    = top_s_ff[VW-1:0];
   assign t1       = time_ff + CW'(1);
   assign dm1      = depth_ff - CW'(1);
   assign dm2      = depth_ff - CW'(2);
   assign adj_row  = adj_rdata & {MAX_VERTICES{row_vld_q_ff}};
   assign {e_v, e_s, e_disc, e_low, e_par} = stk_rdata;

   // scan and emit decisions
   assign hit       = top_row_ff[s_idx] && !((depth_ff >= CW'(2)) && (top_par_ff == s_idx));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ev_hit    = mask_ff[ev_ff];
   assign last_item = (sent_ff + CW'(1)) == count_ff;

   // status to the controller
   always_comb begin
      st.req_add      = (req_data.opcode == apf_pkg::OP_ADD);
      st.req_bad      = (FW'(req_data.from_vertex) >= n_full) ||
                        (FW'(req_data.to_vertex) >= n_full);
      st.root_done    = (root_ff >= n);
      st.root_visited = visited_ff[root_idx];
      st.scan_done    = (top_s_ff >= n);
      st.scan_back    = hit && visited_ff[s_idx];
      st.scan_push    = hit && !visited_ff[s_idx] && (depth_ff < CW'(MAX_VERTICES));
      st.depth_one    = (depth_ff == CW'(1));
      st.emit_done    = out_free && ((count_ff == '0) || (ev_hit && last_item));
   end

   // command execution
   always_comb begin
      vc_in        = csr_we ? csr_wdata : vc_ff;
      item_in      = item_ff;
      bad_in       = bad_ff;
      time_in      = time_ff;
      root_in      = root_ff;
      depth_in     = depth_ff;
      top_v_in     = top_v_ff;
      top_s_in     = top_s_ff;
      top_disc_in  = top_disc_ff;
      top_low_in   = top_low_ff;
      top_par_in   = top_par_ff;
      top_row_in   = top_row_ff;
      child_low_in = child_low_ff;
      rc_in        = rc_ff;
      visited_in   = visited_ff;
      row_valid_in = row_valid_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      ev_in        = ev_ff;
      sent_in      = sent_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      adj_we       = 1'b0;
      adj_waddr    = a_idx;
      adj_wdata    = adj_row;
      adj_raddr    = a_idx;
      disc_we      = 1'b0;
      disc_waddr   = s_idx;
      disc_wdata   = t1;
      disc_raddr   = s_idx;
      stk_we       = 1'b0;
      stk_waddr    = dm1[VW-1:0];
      stk_wdata    = {top_v_ff, top_s_ff + CW'(1), top_disc_ff, top_low_ff, top_par_ff};
      stk_raddr    = dm2[VW-1:0];
      unique case (cmd.op)
         apf_pkg::CMD_ACCEPT: begin
            item_in = req_data;
            if (st.req_add && st.req_bad) begin
               bad_in = 1'b1;
            end
         end
         apf_pkg::CMD_EDGE_RDA: begin
            adj_raddr = a_idx;
         end
         apf_pkg::CMD_EDGE_WRA: begin
            adj_we              = 1'b1;
            adj_waddr           = a_idx;
            adj_wdata           = adj_row | (MAX_VERTICES'(1) << b_idx);
            row_valid_in[a_idx] = 1'b1;
         end
         apf_pkg::CMD_EDGE_RDB: begin
            adj_raddr = b_idx;
         end
         apf_pkg::CMD_EDGE_WRB: begin
            adj_we              = 1'b1;
            adj_waddr           = b_idx;
            adj_wdata           = adj_row | (MAX_VERTICES'(1) << a_idx);
            row_valid_in[b_idx] = 1'b1;
         end
         apf_pkg::CMD_RUN_INIT: begin
            visited_in = '0;
            time_in    = '0;
            root_in    = '0;
            mask_in    = '0;
            count_in   = '0;
            ev_in      = '0;
            sent_in    = '0;
         end
         apf_pkg::CMD_ROOT_SKIP: begin
            root_in = root_ff + CW'(1);
         end
         apf_pkg::CMD_PUSH_ROOT: begin
            depth_in             = CW'(1);
            top_v_in             = root_idx;
            top_s_in             = '0;
            top_disc_in          = t1;
            top_low_in           = t1;
            time_in              = t1;
            rc_in                = '0;
            visited_in[root_idx] = 1'b1;
            disc_we              = 1'b1;
            disc_waddr           = root_idx;
            adj_raddr            = root_idx;
         end
         apf_pkg::CMD_LOAD_ROW: begin
            top_row_in = adj_row;
         end
         apf_pkg::CMD_SCAN: begin
            if (st.scan_done) begin
               // pop; parent entry is read for the restore step
               depth_in     = dm1;
               child_low_in = top_low_ff;
            end else begin
               top_s_in = top_s_ff + CW'(1);
               if (st.scan_push) begin
                  stk_we            = 1'b1;
                  top_par_in        = top_v_ff;
                  top_v_in          = s_idx;
                  top_s_in          = '0;
                  top_disc_in       = t1;
                  top_low_in        = t1;
                  time_in           = t1;
                  visited_in[s_idx] = 1'b1;
                  disc_we           = 1'b1;
                  adj_raddr         = s_idx;
                  depth_in          = depth_ff + CW'(1);
               end
            end
         end
         apf_pkg::CMD_POP: begin
            top_v_in    = e_v;
            top_s_in    = e_s;
            top_disc_in = e_disc;
            top_par_in  = e_par;
            top_low_in  = (child_low_ff < e_low) ? child_low_ff : e_low;
            adj_raddr   = e_v;
            if (depth_ff == CW'(1)) begin
               rc_in = rc_ff + CW'(1);
            end else if (child_low_ff >= e_disc) begin
               mask_in[e_v] = 1'b1;
               if (!mask_ff[e_v]) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         apf_pkg::CMD_BACK: begin
            if (disc_rdata < top_low_ff) begin
               top_low_in = disc_rdata;
            end
         end
         apf_pkg::CMD_WALK_END: begin
            root_in = root_ff + CW'(1);
            if (rc_ff > CW'(1)) begin
               mask_in[root_idx] = 1'b1;
               if (!mask_ff[root_idx]) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         apf_pkg::CMD_EMIT: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.ap_vertex      = '0;
                  rsp_in.ap_count       = '0;
                  rsp_in.none_found     = 1'b1;
                  rsp_in.bad_edge_seen  = bad_ff;
                  rsp_in.is_last        = 1'b1;
               end
            end else if (!ev_hit) begin
               ev_in = ev_ff + VW'(1);
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.ap_vertex      = apf_pkg::VERTEX_W'(ev_ff);
               rsp_in.ap_count       = apf_pkg::VERTEX_W'(count_ff);
               rsp_in.none_found     = 1'b0;
               rsp_in.bad_edge_seen  = bad_ff;
               rsp_in.is_last        = last_item;
               sent_in               = sent_ff + CW'(1);
               ev_in                 = ev_ff + VW'(1);
            end
         end
         apf_pkg::CMD_CLEAR: begin
            row_valid_in = '0;
            mask_in      = '0;
            count_in     = '0;
            bad_in       = 1'b0;
            depth_in     = '0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= apf_pkg::VCOUNT_RESET;
         bad_ff       <= 1'b0;
         time_ff      <= '0;
         root_ff      <= '0;
         depth_ff     <= '0;
         rc_ff        <= '0;
         visited_ff   <= '0;
         row_valid_ff <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
         ev_ff        <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vc_ff        <= vc_in;
         bad_ff       <= bad_in;
         time_ff      <= time_in;
         root_ff      <= root_in;
         depth_ff     <= depth_in;
         rc_ff        <= rc_in;
         visited_ff   <= visited_in;
         row_valid_ff <= row_valid_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         ev_ff        <= ev_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      top_v_ff     <= top_v_in;
      top_s_ff     <= top_s_in;
      top_disc_ff  <= top_disc_in;
      top_low_ff   <= top_low_in;
      top_par_ff   <= top_par_in;
      top_row_ff   <= top_row_in;
      child_low_ff <= child_low_in;
      rsp_ff       <= rsp_in;
      row_vld_q_ff <= row_valid_ff[adj_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack never exceeds the vertex capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CW'(MAX_VERTICES))
      else $error("walk stack depth out of range");

   // a push grows the stack by exactly one
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == apf_pkg::CMD_SCAN && !st.scan_done && st.scan_push)
      |=> depth_ff == $past(depth_ff) + CW'(1))
      else $error("push did not grow the stack");

   // an empty-run result is always the single final item
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.none_found) |-> (rsp_ff.is_last && rsp_ff.ap_count == '0))
      else $error("empty result not marked last");

endmodule

// File: rtl/articulation_point_finder_top.sv
`timescale 1ns / 1ps
// Sequence: an edge load steps through read and write of the first endpoint's row, then of
// the second's (a dropped edge ends at accept); a run does the one-bit-per-cycle adjacency
// scan, with a back-edge step per non-tree adjacency bit, then the emit scan plus result stalls.
// Throughput: one item at a time; results leave at most one per cycle when not stalled.
// Reset: synchronous, clears the graph, flags, point mask and vertex count to 64.
// ---------------------------------------------------------------------------
// articulation_point_finder_top: articulation point finder top level
// Joins the sequencer and the datapath to the request, result and csr ports.
// ---------------------------------------------------------------------------
module articulation_point_finder_top #(
   parameter int MAX_VERTICES = apf_pkg::MAX_VERT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  apf_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output apf_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [apf_pkg::CFG_W-1:0] csr_wdata
);

   apf_pkg::cmd_type    cmd;
   apf_pkg::status_type st;

   apf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .st(st), .cmd(cmd)
   );

   apf_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

endmodule
